/* sv/qpd_pkg.sv */
package qpd_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CHAR_EQ    = 8'h3D;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [1:0] {
      MODE_NORMAL    = 2'd0,
      MODE_EQ        = 2'd1,
      MODE_EQ_CR     = 2'd2,
      MODE_ONE_DIGIT = 2'd3
   } qpd_mode_type;

   // decoded bytes of one input item; cnt == 0 marks an empty message end
   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [1:0] cnt;
      logic       last;
   } qpd_rec_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

   function automatic logic is_pass(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF ||
             (c >= CHAR_BANG && c <= CHAR_TILDE && c != CHAR_EQ);
   endfunction

endpackage

/* sv/qpd_front.sv */
module qpd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_accept,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output logic                rec_push,
   output qpd_pkg::qpd_rec_type rec
);
   import qpd_pkg::*;

   qpd_mode_type mode_ff, mode_in;
   logic [7:0]   held_ff, held_in;
   logic [7:0]   decoded;

   assign decoded = {hex_value(held_ff), hex_value(in_byte)};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         held_ff <= 8'h00;
      end else if (in_accept) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      held_in = held_ff;
      case (mode_ff)
         MODE_NORMAL: begin
            if (in_byte == CHAR_EQ) mode_in = MODE_EQ;
         end
         MODE_EQ, MODE_EQ_CR: begin
            if (in_byte == CHAR_LF) begin
               mode_in = MODE_NORMAL;
            end else if (in_byte == CHAR_CR && mode_ff == MODE_EQ) begin
               mode_in = MODE_EQ_CR;
            end else if (is_hex(in_byte)) begin
               mode_in = MODE_ONE_DIGIT;
               held_in = in_byte;
            end else begin
               mode_in = MODE_NORMAL;
            end
         end
         MODE_ONE_DIGIT: begin
            held_in = 8'h00;
            mode_in = (in_byte == CHAR_EQ) ? MODE_EQ : MODE_NORMAL;
         end
         default: mode_in = MODE_NORMAL;
      endcase
      if (in_last) begin
         mode_in = MODE_NORMAL;
         held_in = 8'h00;
      end
   end

   always_comb begin
      rec      = '0;
      rec.last = in_last;
      case (mode_ff)
         MODE_NORMAL: begin
            if (is_pass(in_byte)) begin
               rec.b0  = in_byte;
               rec.cnt = 2'd1;
            end
         end
         MODE_EQ, MODE_EQ_CR: begin
            if (in_byte == CHAR_LF) begin
               rec.cnt = 2'd0;
            end else if (in_byte == CHAR_CR && mode_ff == MODE_EQ) begin
               rec.cnt = 2'd0;
            end else if (is_hex(in_byte)) begin
               // digit held; a message end flushes it literally
               if (in_last) begin
                  rec.b0  = CHAR_EQ;
                  rec.b1  = in_byte;
                  rec.cnt = 2'd2;
               end
            end else begin
               rec.b0  = CHAR_EQ;
               rec.b1  = in_byte;
               rec.cnt = 2'd2;
            end
         end
         MODE_ONE_DIGIT: begin
            if (is_hex(in_byte)) begin
               if (decoded == CHAR_TAB || decoded >= CHAR_SPACE) begin
                  rec.b0  = decoded;
                  rec.cnt = 2'd1;
               end
            end else begin
               rec.b0  = CHAR_EQ;
               rec.b1  = held_ff;
               rec.cnt = 2'd2;
               if (is_pass(in_byte)) begin
                  rec.b2  = in_byte;
                  rec.cnt = 2'd3;
               end
            end
         end
         default: rec.cnt = 2'd0;
      endcase
   end

   assign rec_push = in_accept && (rec.cnt != 2'd0 || in_last);

endmodule

/* sv/qpd_queue.sv */
module qpd_queue #(
   parameter int DEPTH = qpd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  qpd_pkg::qpd_rec_type push_rec,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output qpd_pkg::qpd_rec_type head_rec
);
   import qpd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   qpd_rec_type   mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full     = count_ff == CW'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_rec = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_rec;
   end

endmodule

/* sv/qpd_back.sv */
module qpd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  qpd_pkg::qpd_rec_type head_rec,
   input  logic                 q_empty,
   input  logic                 out_pop,
   output logic                 q_pop,
   output logic [7:0]           out_byte,
   output logic                 byte_valid,
   output logic                 run_last,
   output logic                 msg_end
);
   import qpd_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic [1:0] final_idx;
   logic       transfer;

   assign final_idx  = (head_rec.cnt == 2'd0) ? 2'd0 : head_rec.cnt - 2'd1;
   assign run_last   = idx_ff == final_idx;
   assign msg_end    = run_last && head_rec.last;
   assign byte_valid = head_rec.cnt != 2'd0;
   assign transfer   = out_pop && !q_empty;
   assign q_pop      = transfer && run_last;

   always_comb begin
      case (idx_ff)
         2'd0:    out_byte = byte_valid ? head_rec.b0 : 8'h00;
         2'd1:    out_byte = head_rec.b1;
         default: out_byte = head_rec.b2;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (transfer) idx_in = run_last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

/* sv/quoted_printable_decoder_core.sv */
// Channel   Ports                                                 Transfer when
// req       req_push, req_full, req_in_byte, req_in_last          push & !full
// rsp       rsp_pop, rsp_empty, rsp_out_byte, rsp_byte_valid,      pop & !empty
//           rsp_run_last, rsp_msg_end
//
// One input byte per cycle while req_full is low; the front decodes it in the
// cycle it is taken. Results leave the record queue one per cycle while rsp_pop
// is high and rsp_empty is low, so a byte's two or three results take turns.
// req_full rises when QUEUE_DEPTH records are waiting.
// Synchronous reset clears the escape state and empties the queue.
module quoted_printable_decoder_core #(
   parameter int QUEUE_DEPTH = qpd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_msg_end
);
   import qpd_pkg::*;

   qpd_rec_type rec, head_rec;
   logic        rec_push, q_pop, accept;

   assign accept = req_push && !req_full;

   qpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_byte   (req_in_byte),
      .in_last   (req_in_last),
      .rec_push  (rec_push),
      .rec       (rec)
   );

   qpd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rec_push),
      .push_rec (rec),
      .full     (req_full),
      .pop      (q_pop),
      .empty    (rsp_empty),
      .head_rec (head_rec)
   );

   qpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_rec   (head_rec),
      .q_empty    (rsp_empty),
      .out_pop    (rsp_pop),
      .q_pop      (q_pop),
      .out_byte   (rsp_out_byte),
      .byte_valid (rsp_byte_valid),
      .run_last   (rsp_run_last),
      .msg_end    (rsp_msg_end)
   );

endmodule
